// File: design/qpcu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qpcu_pkg
// Shared types, register map and count helpers for the pulse counter unit.
// ---------------------------------------------------------------------------
package qpcu_pkg;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int CNT_W  = 16;

  typedef enum logic [2:0] {
    REG_CHAN0_MODES    = 3'd0,
    REG_CHAN1_MODES    = 3'd1,
    REG_EVENT_ENABLES  = 3'd2,
    REG_THRESHOLD_ZERO = 3'd3,
    REG_THRESHOLD_ONE  = 3'd4,
    REG_LOW_LIMIT      = 3'd5,
    REG_HIGH_LIMIT     = 3'd6,
    REG_IRQ_ENABLE     = 3'd7
  } reg_idx_t;

  localparam int EV_LOW   = 0;
  localparam int EV_HIGH  = 1;
  localparam int EV_THR0  = 2;
  localparam int EV_THR1  = 3;
  localparam int EV_ZERO  = 4;

  localparam logic [1:0] EDGE_UP   = 2'd1;
  localparam logic [1:0] EDGE_DOWN = 2'd2;
  localparam logic [1:0] CTL_KEEP  = 2'd0;
  localparam logic [1:0] CTL_REV   = 2'd1;

  typedef struct packed {
    logic [7:0]              chan0_modes;
    logic [7:0]              chan1_modes;
    logic [4:0]              event_enables;
    logic signed [CNT_W-1:0] threshold_zero;
    logic signed [CNT_W-1:0] threshold_one;
    logic signed [CNT_W-1:0] low_limit;
    logic signed [CNT_W-1:0] high_limit;
    logic                    irq_enable;
  } cfg_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_HOLD  = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic     edge0;
    step_t    step0;
    logic     edge1;
    step_t    step1;
  } op_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] cnt;
    logic                    flag;
  } cnt_state_t;

  // step of one channel after edge mode and control mode
  function automatic step_t classify(input logic [7:0] modes, input logic level,
                                     input logic ctl);
    logic [1:0] edge_mode;
    logic [1:0] ctl_mode;
    step_t      s;
    edge_mode = level ? modes[1:0] : modes[3:2];
    ctl_mode  = ctl ? modes[7:6] : modes[5:4];
    if (edge_mode == EDGE_UP) begin
      s = STEP_UP;
    end else if (edge_mode == EDGE_DOWN) begin
      s = STEP_DOWN;
    end else begin
      s = STEP_NONE;
    end
    if (ctl_mode == CTL_REV) begin
      if (s == STEP_UP) begin
        s = STEP_DOWN;
      end else if (s == STEP_DOWN) begin
        s = STEP_UP;
      end
    end else if (ctl_mode != CTL_KEEP) begin
      s = STEP_NONE;
    end
    return s;
  endfunction

  // one counted edge: step, reset to zero at a limit, and event checks
  function automatic cnt_state_t apply_edge(input cnt_state_t st, input step_t stp,
                                            input cfg_t cfg);
    cnt_state_t              r;
    logic signed [CNT_W-1:0] val;
    r = st;
    case (stp)
      STEP_UP:   val = st.cnt + CNT_W'(1);
      STEP_DOWN: val = st.cnt - CNT_W'(1);
      default:   val = st.cnt;
    endcase
    if ((cfg.event_enables[EV_LOW] && ($signed(val) <= $signed(cfg.low_limit))) ||
        (cfg.event_enables[EV_HIGH] && ($signed(val) >= $signed(cfg.high_limit)))) begin
      val    = '0;
      r.flag = 1'b1;
    end
    if (cfg.event_enables[EV_THR0] && (val == cfg.threshold_zero)) begin
      r.flag = 1'b1;
    end
    if (cfg.event_enables[EV_THR1] && (val == cfg.threshold_one)) begin
      r.flag = 1'b1;
    end
    if (cfg.event_enables[EV_ZERO] && (val == '0)) begin
      r.flag = 1'b1;
    end
    r.cnt = val;
    return r;
  endfunction

endpackage

// File: design/qpcu_channels.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qpcu channels
// Valid/ready channel interfaces for pin samples and counter results.
// ---------------------------------------------------------------------------
interface qpcu_in_if;
  logic valid;
  logic ready;
  logic action;
  logic sig0_level;
  logic ctrl0_level;
  logic sig1_level;
  logic ctrl1_level;
  logic pause;
  logic hold_reset;

  modport source (output valid, action, sig0_level, ctrl0_level, sig1_level,
                  ctrl1_level, pause, hold_reset, input ready);
  modport sink (input valid, action, sig0_level, ctrl0_level, sig1_level,
                ctrl1_level, pause, hold_reset, output ready);
endinterface

interface qpcu_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] count_value;
  logic               irq_raw;
  logic               irq_status;
  logic               thresh0_match;
  logic               thresh1_match;
  logic               low_limit_match;
  logic               high_limit_match;
  logic               zero_match;

  modport source (output valid, count_value, irq_raw, irq_status, thresh0_match,
                  thresh1_match, low_limit_match, high_limit_match, zero_match,
                  input ready);
  modport sink (input valid, count_value, irq_raw, irq_status, thresh0_match,
                thresh1_match, low_limit_match, high_limit_match, zero_match,
                output ready);
endinterface

// File: design/qpcu_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qpcu_regs
// APB-style configuration register file.
// ---------------------------------------------------------------------------
module qpcu_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qpcu_pkg::CFG_AW-1:0]   paddr,
  input  logic [qpcu_pkg::CFG_DW-1:0]   pwdata,
  output logic [qpcu_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output qpcu_pkg::cfg_t                cfg
);
  import qpcu_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_CHAN0_MODES:    cfg_nxt.chan0_modes    = pwdata[7:0];
        REG_CHAN1_MODES:    cfg_nxt.chan1_modes    = pwdata[7:0];
        REG_EVENT_ENABLES:  cfg_nxt.event_enables  = pwdata[4:0];
        REG_THRESHOLD_ZERO: cfg_nxt.threshold_zero = pwdata[15:0];
        REG_THRESHOLD_ONE:  cfg_nxt.threshold_one  = pwdata[15:0];
        REG_LOW_LIMIT:      cfg_nxt.low_limit      = pwdata[15:0];
        REG_HIGH_LIMIT:     cfg_nxt.high_limit     = pwdata[15:0];
        REG_IRQ_ENABLE:     cfg_nxt.irq_enable     = pwdata[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CHAN0_MODES:    prdata = CFG_DW'(cfg_r.chan0_modes);
      REG_CHAN1_MODES:    prdata = CFG_DW'(cfg_r.chan1_modes);
      REG_EVENT_ENABLES:  prdata = CFG_DW'(cfg_r.event_enables);
      REG_THRESHOLD_ZERO: prdata = CFG_DW'($unsigned(cfg_r.threshold_zero));
      REG_THRESHOLD_ONE:  prdata = CFG_DW'($unsigned(cfg_r.threshold_one));
      REG_LOW_LIMIT:      prdata = CFG_DW'($unsigned(cfg_r.low_limit));
      REG_HIGH_LIMIT:     prdata = CFG_DW'($unsigned(cfg_r.high_limit));
      REG_IRQ_ENABLE:     prdata = CFG_DW'(cfg_r.irq_enable);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: design/qpcu_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qpcu_front
// Accepts pin samples, detects signal edges and classifies count steps.
// ---------------------------------------------------------------------------
module qpcu_front (
  input  logic            clk,
  input  logic            rst_n,
  qpcu_in_if.sink         in_ch,
  input  qpcu_pkg::cfg_t  cfg,
  input  logic            q_full,
  output logic            q_push,
  output qpcu_pkg::op_t   q_op
);
  import qpcu_pkg::*;

  logic last_sig0_r, last_sig0_nxt;
  logic last_sig1_r, last_sig1_nxt;
  logic take;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && !q_full;
  assign q_push      = take;

  always_comb begin
    q_op          = '0;
    last_sig0_nxt = last_sig0_r;
    last_sig1_nxt = last_sig1_r;
    if (in_ch.action) begin
      q_op.kind = OP_CLEAR;
    end else begin
      last_sig0_nxt = in_ch.sig0_level;
      last_sig1_nxt = in_ch.sig1_level;
      if (in_ch.hold_reset) begin
        q_op.kind = OP_HOLD;
      end else begin
        q_op.kind = OP_TICK;
        if (!in_ch.pause) begin
          q_op.edge0 = in_ch.sig0_level != last_sig0_r;
          q_op.edge1 = in_ch.sig1_level != last_sig1_r;
        end
      end
    end
    q_op.step0 = classify(cfg.chan0_modes, in_ch.sig0_level, in_ch.ctrl0_level);
    q_op.step1 = classify(cfg.chan1_modes, in_ch.sig1_level, in_ch.ctrl1_level);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sig0_r <= 1'b0;
      last_sig1_r <= 1'b0;
    end else if (take) begin
      last_sig0_r <= last_sig0_nxt;
      last_sig1_r <= last_sig1_nxt;
    end
  end

endmodule

// File: design/qpcu_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qpcu_fifo
// Two-entry queue of classified operations between front and back.
// ---------------------------------------------------------------------------
module qpcu_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  qpcu_pkg::op_t  push_op,
  input  logic           pop,
  output qpcu_pkg::op_t  head_op,
  output logic           empty,
  output logic           full
);
  import qpcu_pkg::*;

  op_t        mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign empty   = cnt_r == 2'd0;
  assign full    = cnt_r == 2'd2;
  assign head_op = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: design/qpcu_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qpcu_back
// Applies queued operations to the counter and event flag, drives results.
// ---------------------------------------------------------------------------
module qpcu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  qpcu_pkg::cfg_t  cfg,
  input  qpcu_pkg::op_t   head_op,
  input  logic            q_empty,
  output logic            q_pop,
  qpcu_out_if.source      out_ch
);
  import qpcu_pkg::*;

  cnt_state_t st_r, st_nxt;
  cnt_state_t st_mid;
  logic       out_valid_r, out_valid_nxt;

  assign q_pop = !q_empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    st_nxt = st_r;
    st_mid = st_r;
    case (head_op.kind)
      OP_CLEAR: st_nxt.flag = 1'b0;
      OP_HOLD:  st_nxt.cnt  = '0;
      default: begin
        if (head_op.edge0) begin
          st_mid = apply_edge(st_r, head_op.step0, cfg);
        end
        st_nxt = st_mid;
        if (head_op.edge1) begin
          st_nxt = apply_edge(st_mid, head_op.step1, cfg);
        end
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        st_r <= st_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // result fields follow the live state, which holds while the result waits
  assign out_ch.valid            = out_valid_r;
  assign out_ch.count_value      = st_r.cnt;
  assign out_ch.irq_raw          = st_r.flag;
  assign out_ch.irq_status       = st_r.flag && cfg.irq_enable;
  assign out_ch.thresh0_match    = st_r.cnt == cfg.threshold_zero;
  assign out_ch.thresh1_match    = st_r.cnt == cfg.threshold_one;
  assign out_ch.low_limit_match  = $signed(st_r.cnt) <= $signed(cfg.low_limit);
  assign out_ch.high_limit_match = $signed(st_r.cnt) >= $signed(cfg.high_limit);
  assign out_ch.zero_match       = st_r.cnt == '0;

  a_clear_drops_flag: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && (head_op.kind == OP_CLEAR) |=> !st_r.flag)
    else $error("flag still set after clear");

  a_hold_zeroes_count: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && (head_op.kind == OP_HOLD) |=> (st_r.cnt == '0) && $stable(st_r.flag))
    else $error("hold did not zero the counter");

  a_no_edge_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && (head_op.kind == OP_TICK) && !head_op.edge0 && !head_op.edge1
    |=> $stable(st_r))
    else $error("state changed without a counted edge");

  a_stall_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(st_r) && out_valid_r)
    else $error("state changed while result stalled");

endmodule

// File: design/quadrature_pulse_counter_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadrature_pulse_counter_unit
// Two-channel pulse counter with limits, thresholds and a sticky interrupt.
//
// in_ch carries one transaction per sampled tick of the pins, or a request
// to clear the interrupt flag (action high). out_ch returns one transaction
// per input transaction, in order, with the counter value, the sticky flag
// and the compare results against the configured thresholds and limits.
// The configuration port is APB-style: write in a setup and an access
// cycle, pready is always high; the user must see that registers are
// written only while idle, which the block does not enforce. The front
// stage detects edges and classifies steps, a two-entry queue decouples it
// from the back stage, which updates the counter once per cycle while the
// queue has an entry and no result is stalled (both channels in one cycle,
// channel zero first). Throughput: one per cycle while out_ch.ready is high.
// Reset (rst_n low, synchronous) clears the registers, counter, flag and
// the last signal levels. When the receiver stalls, the result holds and
// the queue takes up to two more inputs before in_ch.ready drops.
// ---------------------------------------------------------------------------
module quadrature_pulse_counter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  qpcu_in_if.sink                       in_ch,
  qpcu_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qpcu_pkg::CFG_AW-1:0]   paddr,
  input  logic [qpcu_pkg::CFG_DW-1:0]   pwdata,
  output logic [qpcu_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import qpcu_pkg::*;

  cfg_t cfg;
  op_t  push_op;
  op_t  head_op;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;

  qpcu_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qpcu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (push),
    .q_op   (push_op)
  );

  qpcu_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .empty   (q_empty),
    .full    (q_full)
  );

  qpcu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .head_op (head_op),
    .q_empty (q_empty),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

// File: sim/quadrature_pulse_counter_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadrature_pulse_counter_unit_tb
// Self-checking bench for the two-channel pulse counter. A short table of
// directed samples and register writes comes first, then rounds of random
// pin samples under changing register settings and handshake pressure.
// Every result transaction is compared in order against a behavioral
// predictor kept alongside the block; typed table rows give count and flag.
// ---------------------------------------------------------------------------
module quadrature_pulse_counter_unit_tb;
  import qpcu_pkg::*;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;
  localparam int   CYCLE_LIMIT = 500000;
  localparam int   LONG_STALL  = 64;
  localparam int   ROUNDS      = 15;
  localparam int   ROUND_ITEMS = 100;

  typedef struct packed {
    logic action;
    logic sig0;
    logic ctl0;
    logic sig1;
    logic ctl1;
    logic pause;
    logic hold;
  } pin_sample_t;

  typedef struct packed {
    logic signed [15:0] count;
    logic               raw;
    logic               status;
    logic               thr0_hit;
    logic               thr1_hit;
    logic               lo_hit;
    logic               hi_hit;
    logic               zero_hit;
  } tally_out_t;

  typedef struct {
    logic               is_cfg;
    reg_idx_t           idx;
    logic [15:0]        data;
    pin_sample_t        pins;
    logic               typed;
    logic signed [15:0] cnt;
    logic               raw;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  qpcu_in_if  in_ch ();
  qpcu_out_if out_ch ();

  quadrature_pulse_counter_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of registers and counter state
  logic [7:0]         mode_ch0 = '0;
  logic [7:0]         mode_ch1 = '0;
  logic [4:0]         ev_en = '0;
  logic signed [15:0] thr_a = '0;
  logic signed [15:0] thr_b = '0;
  logic signed [15:0] lim_lo = '0;
  logic signed [15:0] lim_hi = '0;
  logic               irq_en = 1'b0;
  logic signed [15:0] tally = '0;
  logic               last0 = 1'b0;
  logic               last1 = 1'b0;
  logic               irq_flag = 1'b0;

  tally_out_t  awaited_tallies[$];
  plan_row_t   plan[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          stall_asked = 0;
  int          stall_served = 0;
  int          stall_left = 0;
  logic        typed_flag;
  logic signed [15:0] typed_cnt;
  logic        typed_raw;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void tally_edge(input logic [7:0] modes, input logic lvl,
                                     input logic ctl);
    logic [1:0]         em;
    logic [1:0]         cm;
    logic signed [15:0] delta;
    logic signed [15:0] v;
    em = lvl ? modes[1:0] : modes[3:2];
    cm = ctl ? modes[7:6] : modes[5:4];
    delta = (em == EDGE_UP) ? 16'sd1 : (em == EDGE_DOWN) ? -16'sd1 : 16'sd0;
    if (cm == CTL_REV) begin
      delta = -delta;
    end else if (cm != CTL_KEEP) begin
      delta = '0;
    end
    v = tally + delta;
    if ((ev_en[EV_LOW] && v <= lim_lo) || (ev_en[EV_HIGH] && v >= lim_hi)) begin
      v = '0;
      irq_flag = 1'b1;
    end
    if (ev_en[EV_THR0] && v == thr_a) irq_flag = 1'b1;
    if (ev_en[EV_THR1] && v == thr_b) irq_flag = 1'b1;
    if (ev_en[EV_ZERO] && v == 16'sd0) irq_flag = 1'b1;
    tally = v;
  endfunction

  function automatic tally_out_t predict_tally(input pin_sample_t p);
    tally_out_t r;
    if (p.action == ACT_CLEAR) begin
      irq_flag = 1'b0;
    end else begin
      if (p.hold) begin
        tally = '0;
      end else if (!p.pause) begin
        if (p.sig0 != last0) tally_edge(mode_ch0, p.sig0, p.ctl0);
        if (p.sig1 != last1) tally_edge(mode_ch1, p.sig1, p.ctl1);
      end
      last0 = p.sig0;
      last1 = p.sig1;
    end
    r.count    = tally;
    r.raw      = irq_flag;
    r.status   = irq_flag & irq_en;
    r.thr0_hit = (tally == thr_a);
    r.thr1_hit = (tally == thr_b);
    r.lo_hit   = (tally <= lim_lo);
    r.hi_hit   = (tally >= lim_hi);
    r.zero_hit = (tally == 16'sd0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [15:0] want,
                             input logic signed [15:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // result checking and prediction on accepted transactions
  always @(posedge clk) begin
    tally_out_t  want;
    pin_sample_t p;
    if (rst_n === 1'b1) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (awaited_tallies.size() == 0) begin
          mismatches++;
          $error("out_ch: result transaction with nothing awaited");
        end else begin
          want = awaited_tallies.pop_front();
          check_field("count_value", want.count, out_ch.count_value);
          check_field("irq_raw", want.raw, out_ch.irq_raw);
          check_field("irq_status", want.status, out_ch.irq_status);
          check_field("thresh0_match", want.thr0_hit, out_ch.thresh0_match);
          check_field("thresh1_match", want.thr1_hit, out_ch.thresh1_match);
          check_field("low_limit_match", want.lo_hit, out_ch.low_limit_match);
          check_field("high_limit_match", want.hi_hit, out_ch.high_limit_match);
          check_field("zero_match", want.zero_hit, out_ch.zero_match);
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        p = '{in_ch.action, in_ch.sig0_level, in_ch.ctrl0_level, in_ch.sig1_level,
              in_ch.ctrl1_level, in_ch.pause, in_ch.hold_reset};
        want = predict_tally(p);
        if (typed_flag) begin
          want.count = typed_cnt;
          want.raw   = typed_raw;
        end
        awaited_tallies.push_back(want);
      end
    end
  end

  // result side: random back-pressure plus one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_asked != stall_served) begin
        stall_served = stall_asked;
        stall_left   = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic void plan_reg(input reg_idx_t idx, input logic [15:0] data);
    plan_row_t r;
    r = '{idx: REG_CHAN0_MODES, default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    plan.push_back(r);
  endfunction

  function automatic void plan_tick(input logic s0, c0, s1, c1, ps, hd,
                                    input logic typed, input int cnt, input logic raw);
    plan_row_t r;
    r = '{idx: REG_CHAN0_MODES, default: '0};
    r.pins  = '{ACT_TICK, s0, c0, s1, c1, ps, hd};
    r.typed = typed;
    r.cnt   = cnt[15:0];
    r.raw   = raw;
    plan.push_back(r);
  endfunction

  // pause and hold are set on a clear; both must be ignored
  function automatic void plan_clear(input logic s0, c0, s1, c1,
                                     input logic typed, input int cnt, input logic raw);
    plan_row_t r;
    r = '{idx: REG_CHAN0_MODES, default: '0};
    r.pins  = '{ACT_CLEAR, s0, c0, s1, c1, 1'b1, 1'b1};
    r.typed = typed;
    r.cnt   = cnt[15:0];
    r.raw   = raw;
    plan.push_back(r);
  endfunction

  task automatic offer(input pin_sample_t p, input logic typed,
                       input logic signed [15:0] cnt, input logic raw);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.action      <= p.action;
    in_ch.sig0_level  <= p.sig0;
    in_ch.ctrl0_level <= p.ctl0;
    in_ch.sig1_level  <= p.sig1;
    in_ch.ctrl1_level <= p.ctl1;
    in_ch.pause       <= p.pause;
    in_ch.hold_reset  <= p.hold;
    typed_flag        <= typed;
    typed_cnt         <= cnt;
    typed_raw         <= raw;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // stop offering and wait for every awaited result
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_tallies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CHAN0_MODES:    mode_ch0 = v[7:0];
      REG_CHAN1_MODES:    mode_ch1 = v[7:0];
      REG_EVENT_ENABLES:  ev_en    = v[4:0];
      REG_THRESHOLD_ZERO: thr_a    = v;
      REG_THRESHOLD_ONE:  thr_b    = v;
      REG_LOW_LIMIT:      lim_lo   = v;
      REG_HIGH_LIMIT:     lim_hi   = v;
      REG_IRQ_ENABLE:     irq_en   = v[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_bound();
    int v;
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom);
      default: begin
        v = int'($urandom_range(24)) - 12;
        return v[15:0];
      end
    endcase
  endfunction

  // mostly counting edge modes and keep/reverse control modes
  function automatic logic [15:0] pick_modes();
    logic [1:0] f[4];
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(4) == 0) begin
        f[i] = 2'($urandom_range(3));
      end else if (i < 2) begin
        f[i] = $urandom_range(1) ? EDGE_UP : EDGE_DOWN;
      end else begin
        f[i] = $urandom_range(1) ? CTL_KEEP : CTL_REV;
      end
    end
    return {8'h00, f[3], f[2], f[1], f[0]};
  endfunction

  task automatic configure_round(input int r);
    logic [15:0] v;
    quiesce();
    for (int i = 0; i < 8; i++) begin
      case (reg_idx_t'(i))
        REG_CHAN0_MODES, REG_CHAN1_MODES: begin
          v = (r == 5) ? 16'h0000 : (r == 10) ? 16'h00FF : pick_modes();
        end
        REG_EVENT_ENABLES: begin
          v = (r == 0) ? 16'h001F : (r == 5) ? 16'h0000 : 16'($urandom_range(31));
        end
        REG_LOW_LIMIT:  v = (r == 0) ? 16'h8000 : pick_bound();
        REG_HIGH_LIMIT: v = (r == 0) ? 16'h7FFF : pick_bound();
        REG_IRQ_ENABLE: v = 16'($urandom_range(1));
        default:        v = (r == 0) ? 16'h7FFF : pick_bound();
      endcase
      write_reg(reg_idx_t'(i), v);
    end
  endtask

  initial begin
    pin_sample_t p;
    plan_row_t   row;
    logic        lvl0;
    logic        lvl1;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_TICK;
    in_ch.sig0_level  <= 1'b0;
    in_ch.ctrl0_level <= 1'b0;
    in_ch.sig1_level  <= 1'b0;
    in_ch.ctrl1_level <= 1'b0;
    in_ch.pause       <= 1'b0;
    in_ch.hold_reset  <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    typed_flag        <= 1'b0;
    typed_cnt         <= '0;
    typed_raw         <= 1'b0;
    tx_idle_pct = 11;
    rx_idle_pct = 86;
    lvl0 = 1'b0;
    lvl1 = 1'b0;

    // directed table: s0 c0 s1 c1 pause hold, then typed count and flag
    plan_tick(0, 0, 0, 0, 0, 0, 1, 0, 0);
    plan_clear(0, 0, 0, 0, 1, 0, 0);
    plan_reg(REG_CHAN0_MODES, 16'h0045);
    plan_reg(REG_CHAN1_MODES, 16'h001A);
    plan_tick(1, 0, 0, 0, 0, 0, 1, 1, 0);
    plan_tick(1, 0, 1, 0, 0, 0, 1, 2, 0);
    plan_tick(0, 0, 0, 0, 1, 0, 1, 2, 0);
    plan_tick(0, 0, 0, 0, 0, 0, 1, 2, 0);
    plan_tick(1, 1, 1, 1, 0, 0, 1, 0, 0);
    plan_tick(0, 0, 1, 1, 0, 0, 1, 1, 0);
    plan_tick(1, 0, 0, 0, 0, 1, 1, 0, 0);
    plan_reg(REG_EVENT_ENABLES, 16'h001F);
    plan_reg(REG_THRESHOLD_ZERO, 16'h0002);
    plan_reg(REG_THRESHOLD_ONE, 16'hFFFE);
    plan_reg(REG_LOW_LIMIT, 16'hFFFD);
    plan_reg(REG_HIGH_LIMIT, 16'h0003);
    plan_reg(REG_IRQ_ENABLE, 16'h0001);
    plan_tick(0, 0, 0, 0, 0, 0, 1, 1, 0);
    plan_tick(1, 0, 0, 0, 0, 0, 1, 2, 1);
    plan_clear(0, 0, 1, 0, 1, 2, 0);
    plan_tick(0, 0, 0, 0, 0, 0, 1, 0, 1);
    plan_clear(1, 1, 1, 1, 1, 0, 0);
    plan_tick(1, 1, 0, 0, 0, 0, 1, -1, 0);
    plan_tick(0, 1, 0, 0, 0, 0, 1, -2, 1);
    plan_tick(1, 1, 0, 0, 0, 0, 1, 0, 1);
    plan_reg(REG_CHAN0_MODES, 16'h00CF);
    plan_reg(REG_CHAN1_MODES, 16'h00C5);
    plan_clear(0, 0, 0, 0, 1, 0, 0);
    plan_tick(0, 0, 0, 0, 0, 0, 1, 0, 1);
    plan_clear(0, 0, 0, 0, 1, 0, 0);
    plan_tick(1, 1, 1, 1, 0, 0, 1, 0, 1);
    plan_tick(1, 1, 0, 0, 0, 0, 1, 1, 1);
    plan_reg(REG_IRQ_ENABLE, 16'h0000);
    plan_tick(1, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        quiesce();
        write_reg(row.idx, row.data);
      end else begin
        offer(row.pins, row.typed, row.cnt, row.raw);
      end
    end

    for (int r = 0; r < ROUNDS; r++) begin
      tx_idle_pct = (r < 5) ? 11 : (r < 10) ? 86 : 0;
      rx_idle_pct = (r < 5) ? 86 : (r < 10) ? 11 : 0;
      configure_round(r);
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        if (r == 11 && n == 30) stall_asked++;
        if (r == 12 && n == 50) quiesce();
        p.action = ($urandom_range(99) < 5) ? ACT_CLEAR : ACT_TICK;
        p.sig0   = $urandom_range(1) ? ~lvl0 : lvl0;
        p.sig1   = $urandom_range(1) ? ~lvl1 : lvl1;
        p.ctl0   = $urandom_range(1);
        p.ctl1   = $urandom_range(1);
        p.pause  = ($urandom_range(99) < 8);
        p.hold   = ($urandom_range(99) < 4);
        if (p.action == ACT_TICK) begin
          lvl0 = p.sig0;
          lvl1 = p.sig1;
        end
        offer(p, 1'b0, '0, 1'b0);
      end
    end

    quiesce();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
design/qpcu_pkg.sv
design/qpcu_channels.sv
design/qpcu_regs.sv
design/qpcu_front.sv
design/qpcu_fifo.sv
design/qpcu_back.sv
design/quadrature_pulse_counter_unit.sv
sim/quadrature_pulse_counter_unit_tb.sv
